>>> design/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg
// Shared constants, codes and handoff types for the voice steal selector.
// ----------------------------------------------------------------------------
package vss_pkg;

    localparam int MAX_VOICES_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;

    // Index fields in handoff types are sized for the largest voice count (512)
    localparam int VIDX_W   = 9;
    localparam int VCNT_W   = VIDX_W + 1;
    localparam int VICTIM_W = 6;
    localparam int NOTE_W   = 7;
    localparam int STAMP_W  = 32;

    typedef enum logic [2:0] {
        TIER_EXACT    = 3'd0,
        TIER_RELEASED = 3'd1,
        TIER_KEY_UP   = 3'd2,
        TIER_ANY      = 3'd3,
        TIER_NEW      = 3'd4,
        TIER_TOP      = 3'd5,
        TIER_LOW      = 3'd6
    } tier_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

    // One closed query, as handed from front to back
    typedef struct packed {
        logic              bank;
        logic [VCNT_W-1:0] count;
        logic              low_valid;
        logic [VIDX_W-1:0] low_idx;
        logic              top_valid;
        logic [VIDX_W-1:0] top_idx;
        logic              exact_valid;
        logic [VIDX_W-1:0] exact_idx;
    } query_t;

    // Back tells front that a bank's records are no longer needed
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

>>> design/vss_if.sv
// ----------------------------------------------------------------------------
// vss_if
// Valid/ready channels for voice records and steal results.
// ----------------------------------------------------------------------------
interface vss_voice_if;
    logic        valid;
    logic        ready;
    logic        can_play;
    logic [6:0]  note;
    logic        released;
    logic        key_down;
    logic        sounding;
    logic [31:0] start_time;
    logic [31:0] burst_begin;
    logic [6:0]  wanted_note;
    logic        final_voice;

    modport source (
        output valid, can_play, note, released, key_down, sounding,
               start_time, burst_begin, wanted_note, final_voice,
        input  ready
    );
    modport sink (
        input  valid, can_play, note, released, key_down, sounding,
               start_time, burst_begin, wanted_note, final_voice,
        output ready
    );
endinterface

interface vss_pick_if;
    logic       valid;
    logic       ready;
    logic [5:0] victim;
    logic [2:0] tier;
    logic       found;

    modport source (
        output valid, victim, tier, found,
        input  ready
    );
    modport sink (
        input  valid, victim, tier, found,
        output ready
    );
endinterface

>>> design/vss_queue.sv
// ----------------------------------------------------------------------------
// vss_queue
// Two-entry FIFO of closed queries between front and back.
// ----------------------------------------------------------------------------
module vss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vss_pkg::query_t push_q,
    output logic            full,
    output logic            not_empty,
    output vss_pkg::query_t head,
    input  logic            pop
);
    import vss_pkg::*;

    query_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !full)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop && not_empty)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if ((push && !full) && !(pop && not_empty))
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && not_empty))
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_q;
        end
    end

endmodule

>>> design/vss_front.sv
// ----------------------------------------------------------------------------
// vss_front
// Takes voice records, stores them into a bank and tracks the low/top held
// notes and the first exact match while they stream in.
// ----------------------------------------------------------------------------
module vss_front #(
    parameter  int MAX_VOICES = vss_pkg::MAX_VOICES_DEF,
    parameter  int TIME_BITS  = vss_pkg::TIME_BITS_DEF,
    localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
    localparam int ADDR_W     = IDX_W + 1,
    localparam int ENTRY_W    = TIME_BITS + 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    vss_voice_if.sink              voice,
    output logic                   mem_wr_en,
    output logic [ADDR_W-1:0]      mem_wr_addr,
    output logic [ENTRY_W-1:0]     mem_wr_data,
    output logic                   push,
    output vss_pkg::query_t        push_q,
    input  logic                   q_full,
    input  vss_pkg::bank_rel_t     rel
);
    import vss_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOICES + 1);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 bank_reg, bank_next;
    logic [1:0]           busy_reg, busy_next;
    logic [NOTE_W-1:0]    wanted_reg, wanted_next;
    logic [TIME_BITS-1:0] burst_reg, burst_next;
    logic                 low_valid_reg, low_valid_next;
    logic [IDX_W-1:0]     low_idx_reg, low_idx_next;
    logic [NOTE_W-1:0]    low_note_reg, low_note_next;
    logic                 top_valid_reg, top_valid_next;
    logic [IDX_W-1:0]     top_idx_reg, top_idx_next;
    logic [NOTE_W-1:0]    top_note_reg, top_note_next;
    logic                 exact_valid_reg, exact_valid_next;
    logic [IDX_W-1:0]     exact_idx_reg, exact_idx_next;

    logic                 accept, first, store, held, is_new;
    logic                 take_low, take_top, take_exact;
    logic                 lo_v, tp_v, ex_v;
    logic [IDX_W-1:0]     cur_idx;
    logic [NOTE_W-1:0]    cur_wanted;
    logic [TIME_BITS-1:0] cur_burst, stamp, burst_in;
    logic [63:0]          stamp_wide, burst_wide;
    logic [CNT_W-1:0]     count_fin;

    assign stamp_wide = 64'(voice.start_time);
    assign burst_wide = 64'(voice.burst_begin);
    assign stamp      = stamp_wide[TIME_BITS-1:0];
    assign burst_in   = burst_wide[TIME_BITS-1:0];

    assign voice.ready = !busy_reg[bank_reg] && !q_full;
    assign accept      = voice.valid && voice.ready;

    assign first      = (count_reg == '0);
    assign store      = (count_reg < CNT_W'(MAX_VOICES));
    assign cur_idx    = count_reg[IDX_W-1:0];
    assign cur_wanted = first ? voice.wanted_note : wanted_reg;
    assign cur_burst  = first ? burst_in : burst_reg;

    // a new query starts with nothing tracked
    assign lo_v = first ? 1'b0 : low_valid_reg;
    assign tp_v = first ? 1'b0 : top_valid_reg;
    assign ex_v = first ? 1'b0 : exact_valid_reg;

    assign held       = voice.can_play && !voice.released;
    assign is_new     = (stamp >= cur_burst) || !voice.sounding;
    assign take_low   = store && held && (!lo_v || voice.note < low_note_reg);
    assign take_top   = store && held && (!tp_v || voice.note > top_note_reg);
    assign take_exact = store && !ex_v && voice.can_play && (voice.note == cur_wanted);
    assign count_fin  = store ? count_reg + CNT_W'(1) : count_reg;

    assign mem_wr_en   = accept && store;
    assign mem_wr_addr = {bank_reg, cur_idx};
    assign mem_wr_data = {voice.can_play, voice.released, voice.key_down, is_new, stamp};

    assign push = accept && voice.final_voice;

    always_comb
    begin
        push_q             = '0;
        push_q.bank        = bank_reg;
        push_q.count       = VCNT_W'(count_fin);
        push_q.low_valid   = take_low ? 1'b1 : lo_v;
        push_q.low_idx     = VIDX_W'(take_low ? cur_idx : low_idx_reg);
        push_q.top_valid   = take_top ? 1'b1 : tp_v;
        push_q.top_idx     = VIDX_W'(take_top ? cur_idx : top_idx_reg);
        // same voice lowest and highest: protect it once, as the low one
        if (push_q.top_valid && push_q.low_valid && push_q.top_idx == push_q.low_idx)
        begin
            push_q.top_valid = 1'b0;
        end
        push_q.exact_valid = take_exact ? 1'b1 : ex_v;
        push_q.exact_idx   = VIDX_W'(take_exact ? cur_idx : exact_idx_reg);
    end

    always_comb
    begin
        count_next       = count_reg;
        bank_next        = bank_reg;
        busy_next        = busy_reg;
        wanted_next      = wanted_reg;
        burst_next       = burst_reg;
        low_valid_next   = low_valid_reg;
        low_idx_next     = low_idx_reg;
        low_note_next    = low_note_reg;
        top_valid_next   = top_valid_reg;
        top_idx_next     = top_idx_reg;
        top_note_next    = top_note_reg;
        exact_valid_next = exact_valid_reg;
        exact_idx_next   = exact_idx_reg;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (first)
            begin
                wanted_next = voice.wanted_note;
                burst_next  = burst_in;
            end
            low_valid_next   = take_low ? 1'b1 : lo_v;
            top_valid_next   = take_top ? 1'b1 : tp_v;
            exact_valid_next = take_exact ? 1'b1 : ex_v;
            if (take_low)
            begin
                low_idx_next  = cur_idx;
                low_note_next = voice.note;
            end
            if (take_top)
            begin
                top_idx_next  = cur_idx;
                top_note_next = voice.note;
            end
            if (take_exact)
            begin
                exact_idx_next = cur_idx;
            end
            if (voice.final_voice)
            begin
                count_next          = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                count_next = count_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            bank_reg        <= 1'b0;
            busy_reg        <= 2'b00;
            wanted_reg      <= '0;
            burst_reg       <= '0;
            low_valid_reg   <= 1'b0;
            top_valid_reg   <= 1'b0;
            exact_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            bank_reg        <= bank_next;
            busy_reg        <= busy_next;
            wanted_reg      <= wanted_next;
            burst_reg       <= burst_next;
            low_valid_reg   <= low_valid_next;
            top_valid_reg   <= top_valid_next;
            exact_valid_reg <= exact_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_idx_reg   <= low_idx_next;
        low_note_reg  <= low_note_next;
        top_idx_reg   <= top_idx_next;
        top_note_reg  <= top_note_next;
        exact_idx_reg <= exact_idx_next;
    end

endmodule

>>> design/vss_back.sv
// ----------------------------------------------------------------------------
// vss_back
// Holds the two record banks and scans a closed query for the oldest
// unprotected voice per class, then forms the steal result.
// ----------------------------------------------------------------------------
module vss_back #(
    parameter  int MAX_VOICES = vss_pkg::MAX_VOICES_DEF,
    parameter  int TIME_BITS  = vss_pkg::TIME_BITS_DEF,
    localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
    localparam int ADDR_W     = IDX_W + 1,
    localparam int ENTRY_W    = TIME_BITS + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mem_wr_en,
    input  logic [ADDR_W-1:0]    mem_wr_addr,
    input  logic [ENTRY_W-1:0]   mem_wr_data,
    input  logic                 q_valid,
    input  vss_pkg::query_t      head,
    output logic                 pop,
    output vss_pkg::bank_rel_t   rel,
    vss_pick_if.source           pick
);
    import vss_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    // candidate classes
    localparam int CL_REL = 0;
    localparam int CL_UP  = 1;
    localparam int CL_ANY = 2;
    localparam int CL_NEW = 3;

    logic [ENTRY_W-1:0] mem [2**ADDR_W];

    back_state_t          state_reg, state_next;
    query_t               cur_q_reg;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 cand_valid_reg [4];
    logic                 cand_valid_next [4];
    logic [IDX_W-1:0]     cand_idx_reg [4];
    logic [IDX_W-1:0]     cand_idx_next [4];
    logic [TIME_BITS-1:0] cand_time_reg [4];
    logic [TIME_BITS-1:0] cand_time_next [4];
    logic                 out_valid_reg, out_valid_next;
    logic [VICTIM_W-1:0]  victim_reg;
    tier_t                tier_reg;
    logic                 found_reg;

    logic                 issue, out_free, finish, skip;
    logic                 e_can, e_rel, e_up_key, e_new;
    logic [TIME_BITS-1:0] e_time;
    logic [3:0]           elig;
    logic [VIDX_W-1:0]    res_idx;
    tier_t                res_tier;
    logic                 res_found;

    assign out_free = !out_valid_reg || pick.ready;
    assign {e_can, e_rel, e_up_key, e_new, e_time} = rd_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (head.exact_valid || head.count == '0)
                    begin
                        state_next = BK_FINISH;
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                if (!issue && !s1_valid_reg)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop    = 1'b0;
        issue  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = q_valid;
            end
            BK_SCAN:
            begin
                issue = (issue_cnt_reg < CNT_W'(cur_q_reg.count));
            end
            BK_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign rel.valid = finish;
    assign rel.bank  = cur_q_reg.bank;

    assign issue_cnt_next = pop ? '0 : (issue ? issue_cnt_reg + CNT_W'(1) : issue_cnt_reg);

    // classify the record that came out of the bank last cycle
    assign skip = !e_can
                  || (cur_q_reg.low_valid && s1_idx_reg == IDX_W'(cur_q_reg.low_idx))
                  || (cur_q_reg.top_valid && s1_idx_reg == IDX_W'(cur_q_reg.top_idx));

    always_comb
    begin
        elig         = '0;
        elig[CL_NEW] = e_new;
        elig[CL_REL] = !e_new && e_rel;
        elig[CL_UP]  = !e_new && !e_up_key;
        elig[CL_ANY] = !e_new;
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            cand_valid_next[c] = cand_valid_reg[c];
            cand_idx_next[c]   = cand_idx_reg[c];
            cand_time_next[c]  = cand_time_reg[c];
            if (pop)
            begin
                cand_valid_next[c] = 1'b0;
            end
            else if (s1_valid_reg && !skip && elig[c]
                     && (!cand_valid_reg[c] || e_time < cand_time_reg[c]))
            begin
                cand_valid_next[c] = 1'b1;
                cand_idx_next[c]   = s1_idx_reg;
                cand_time_next[c]  = e_time;
            end
        end
    end

    always_comb
    begin
        res_found = 1'b1;
        res_idx   = '0;
        res_tier  = TIER_EXACT;
        priority if (cur_q_reg.exact_valid)
        begin
            res_idx  = cur_q_reg.exact_idx;
            res_tier = TIER_EXACT;
        end
        else if (cand_valid_reg[CL_REL])
        begin
            res_idx  = VIDX_W'(cand_idx_reg[CL_REL]);
            res_tier = TIER_RELEASED;
        end
        else if (cand_valid_reg[CL_UP])
        begin
            res_idx  = VIDX_W'(cand_idx_reg[CL_UP]);
            res_tier = TIER_KEY_UP;
        end
        else if (cand_valid_reg[CL_ANY])
        begin
            res_idx  = VIDX_W'(cand_idx_reg[CL_ANY]);
            res_tier = TIER_ANY;
        end
        else if (cand_valid_reg[CL_NEW])
        begin
            res_idx  = VIDX_W'(cand_idx_reg[CL_NEW]);
            res_tier = TIER_NEW;
        end
        else if (cur_q_reg.top_valid)
        begin
            res_idx  = cur_q_reg.top_idx;
            res_tier = TIER_TOP;
        end
        else if (cur_q_reg.low_valid)
        begin
            res_idx  = cur_q_reg.low_idx;
            res_tier = TIER_LOW;
        end
        else
        begin
            res_found = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pick.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign pick.valid  = out_valid_reg;
    assign pick.victim = victim_reg;
    assign pick.tier   = tier_reg;
    assign pick.found  = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            for (int c = 0; c < 4; c++)
            begin
                cand_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= issue;
            out_valid_reg <= out_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            for (int c = 0; c < 4; c++)
            begin
                cand_valid_reg[c] <= cand_valid_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_q_reg <= head;
        end
        s1_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        for (int c = 0; c < 4; c++)
        begin
            cand_idx_reg[c]  <= cand_idx_next[c];
            cand_time_reg[c] <= cand_time_next[c];
        end
        if (finish)
        begin
            victim_reg <= res_idx[VICTIM_W-1:0];
            tier_reg   <= res_tier;
            found_reg  <= res_found;
        end
    end

    // record banks
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[{cur_q_reg.bank, issue_cnt_reg[IDX_W-1:0]}];
        end
    end

endmodule

>>> design/voice_steal_selector.sv
// ----------------------------------------------------------------------------
// voice_steal_selector
// Picks the voice to steal for a note-on from a stream of voice records.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    moves
//  voice    in   valid/ready  one voice record per request, last one flagged
//  pick     out  valid/ready  victim index, tier and found flag per query
//
//  Records load at one per cycle, while input is not stalled, into one of
//  two banks. After the flagged record the scan reads that bank at one
//  record per cycle; the scan is skipped when an exact note match exists
//  or the query is empty. The next query loads into the other bank during
//  the scan; input stalls only while both banks hold queries. A stalled
//  result keeps its bank busy, so loading stops once the other bank has
//  filled as well. Reset is immediate, no clearing pass.
// ----------------------------------------------------------------------------
module voice_steal_selector #(
    parameter  int MAX_VOICES = vss_pkg::MAX_VOICES_DEF,
    parameter  int TIME_BITS  = vss_pkg::TIME_BITS_DEF,
    localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
    localparam int ADDR_W     = IDX_W + 1,
    localparam int ENTRY_W    = TIME_BITS + 4
) (
    input  logic        clk,
    input  logic        rst_n,
    vss_voice_if.sink   voice,
    vss_pick_if.source  pick
);
    import vss_pkg::*;

    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               push, q_full, q_valid, pop;
    query_t             push_q, head;
    bank_rel_t          rel;

    vss_front #(
        .MAX_VOICES (MAX_VOICES),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .voice       (voice),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .push        (push),
        .push_q      (push_q),
        .q_full      (q_full),
        .rel         (rel)
    );

    vss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_q    (push_q),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head),
        .pop       (pop)
    );

    vss_back #(
        .MAX_VOICES (MAX_VOICES),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .rel         (rel),
        .pick        (pick)
    );

endmodule
